// ===== sv/sorted_priority_queue_macros.svh =====
// Assertion macros used by the sorted priority queue checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Check that cond_a implies cond_b in the same cycle.
`define SPQ_ASSERT_SAME(label, clk, rst, cond_a, cond_b) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
      else $error("sorted_priority_queue: same-cycle check failed");

// Check that cond_a implies cond_b in the next cycle.
`define SPQ_ASSERT_NEXT(label, clk, rst, cond_a, cond_b) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
      else $error("sorted_priority_queue: next-cycle check failed");

`endif

// ===== sv/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, command and status codes, cell types.
// Depends on nothing; used by the interfaces, the cell, the top level and the checker.
package spq_pkg;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 16;
   localparam int VALUE_BITS    = 32;
   localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
   localparam int CMD_BITS      = 2;
   localparam int STATUS_BITS   = 2;

   localparam logic [CMD_BITS-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_PEEK    = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic                         enq;
      logic                         deq;
      logic [PRIORITY_BITS-1:0]     prio;
      logic signed [VALUE_BITS-1:0] value;
   } ctrl_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic                         valid;
      logic                         after;  // entry stays ahead of the new one
      logic [PRIORITY_BITS-1:0]     prio;
      logic signed [VALUE_BITS-1:0] value;
   } slot_type;

endpackage

// ===== sv/spq_if.sv =====
// Valid/ready channel interfaces for the sorted priority queue.
// Depends on spq_pkg for field widths.
interface spq_req_if import spq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [CMD_BITS-1:0]          command;
   logic signed [VALUE_BITS-1:0] item_value;
   logic [PRIORITY_BITS-1:0]     item_priority;

   modport source (output valid, command, item_value, item_priority, input ready);
   modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] head_value;
   logic                         head_valid;
   logic [COUNT_BITS-1:0]        occupancy;
   logic [STATUS_BITS-1:0]       status;

   modport source (output valid, head_value, head_valid, occupancy, status, input ready);
   modport sink   (input valid, head_value, head_valid, occupancy, status, output ready);
endinterface

// ===== sv/spq_cell.sv =====
// One slot of the sorted queue: holds an entry and shifts toward either neighbor.
// Depends on spq_pkg for ctrl_type and slot_type.
module spq_cell import spq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  ctrl_type ctrl,
   input  slot_type left,
   input  slot_type right,
   output slot_type slot
);

   logic                         valid_ff, valid_in;
   logic [PRIORITY_BITS-1:0]     prio_ff, prio_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic                         after;

   assign after = valid_ff && (prio_ff <= ctrl.prio);

   always_comb begin
      valid_in = valid_ff;
      prio_in  = prio_ff;
      value_in = value_ff;
      if (ctrl.enq) begin
         if (after) begin
            // hold: entry stays ahead of the new one
         end else if (left.after) begin
            valid_in = 1'b1;
            prio_in  = ctrl.prio;
            value_in = ctrl.value;
         end else begin
            valid_in = left.valid;
            prio_in  = left.prio;
            value_in = left.value;
         end
      end else if (ctrl.deq) begin
         valid_in = right.valid;
         prio_in  = right.prio;
         value_in = right.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prio_ff  <= prio_in;
      value_ff <= value_in;
   end

   assign slot = '{valid: valid_ff, after: after, prio: prio_ff, value: value_ff};

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue: a row of CAPACITY slot cells keeps entries ordered by
// ascending priority, equal priorities in arrival order, front entry in cell 0.
// An enqueue compares its priority in every cell at once; cells at or past the
// insertion point shift one place back and the new entry drops into the gap.
// A dequeue shifts every cell one place forward. Peek (and the unused command
// code) changes nothing. Each transaction updates the row in the cycle it is
// accepted, so the queue takes one request transaction per clock and its
// response transaction appears on the rsp channel in the next cycle, held in an
// output register; a request is accepted while that register is empty or is
// being drained. Enqueue on a full queue and dequeue on an empty queue are
// reported through status and leave the queue untouched. Depends on spq_pkg,
// spq_if and spq_cell.
module sorted_priority_queue import spq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   ctrl_type ctrl;
   slot_type slots [CAPACITY];
   slot_type edge_left, edge_right;

   logic                         accept;
   logic                         is_full, is_empty;
   logic                         cmd_enq, cmd_deq;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic [STATUS_BITS-1:0]       status_in;
   logic signed [VALUE_BITS-1:0] head_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_BITS-1:0] head_value_ff;
   logic                         head_valid_ff;
   logic [COUNT_BITS-1:0]        occupancy_ff;
   logic [STATUS_BITS-1:0]       status_ff;

   // Accept when the response register is free or drains this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_full  = (count_ff == COUNT_BITS'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign cmd_enq  = (req_chan.command == CMD_ENQUEUE);
   assign cmd_deq  = (req_chan.command == CMD_DEQUEUE);

   // Drive the row only for operations that really change it.
   assign ctrl = '{enq:   accept && cmd_enq && !is_full,
                   deq:   accept && cmd_deq && !is_empty,
                   prio:  req_chan.item_priority,
                   value: req_chan.item_value};

   // Front of the row always lets a new entry in; back end feeds empty slots.
   assign edge_left  = '{valid: 1'b1, after: 1'b1, prio: '0, value: '0};
   assign edge_right = '{valid: 1'b0, after: 1'b0, prio: '0, value: '0};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      slot_type left_nb, right_nb;
      if (i == 0) begin : g_first
         assign left_nb = edge_left;
      end else begin : g_mid_l
         assign left_nb = slots[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_nb = edge_right;
      end else begin : g_mid_r
         assign right_nb = slots[i+1];
      end
      spq_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .left  (left_nb),
         .right (right_nb),
         .slot  (slots[i])
      );
   end

   // Work out count, status and the front entry after this operation.
   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      head_in   = slots[0].value;
      case (req_chan.command)
         CMD_ENQUEUE: begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + COUNT_BITS'(1);
               if (!slots[0].after) begin
                  head_in = req_chan.item_value;
               end
            end
         end
         CMD_DEQUEUE: begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - COUNT_BITS'(1);
               head_in  = slots[1].value;
            end
         end
         default: begin
            // peek or unused command code: leave everything as it is
         end
      endcase
      if (count_in == '0) begin
         head_in = '0;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         head_value_ff <= head_in;
         head_valid_ff <= (count_in != '0);
         occupancy_ff  <= count_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.head_value = head_value_ff;
   assign rsp_chan.head_valid = head_valid_ff;
   assign rsp_chan.occupancy  = occupancy_ff;
   assign rsp_chan.status     = status_ff;

endmodule

// ===== sv/spq_checker.sv =====
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_macros.svh.
`include "sorted_priority_queue_macros.svh"

module spq_checker import spq_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [VALUE_BITS-1:0] head_value,
   input logic                         head_valid,
   input logic [COUNT_BITS-1:0]        occupancy,
   input logic [STATUS_BITS-1:0]       status
);

   // A stalled response transaction holds.
   `SPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(occupancy) && $stable(head_value))

   // A rejected enqueue only happens on a full queue.
   `SPQ_ASSERT_SAME(a_full_count, clock, reset, rsp_valid && status == STATUS_FULL, occupancy == COUNT_BITS'(CAPACITY))

   // An empty dequeue leaves an empty queue with a zero head.
   `SPQ_ASSERT_SAME(a_empty_head, clock, reset, rsp_valid && status == STATUS_EMPTY, occupancy == '0 && !head_valid && head_value == '0)

   // Head flag tracks occupancy.
   `SPQ_ASSERT_SAME(a_head_flag, clock, reset, rsp_valid, head_valid == (occupancy != '0))

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .head_value (rsp_chan.head_value),
   .head_valid (rsp_chan.head_valid),
   .occupancy  (rsp_chan.occupancy),
   .status     (rsp_chan.status)
);
